// ===== rtl/assert_macros.svh =====
// shared assertion macros for the resample interpolator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/imr_pkg.sv =====
`default_nettype none

package imr_pkg;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // interpolation modes, the unused code acts as nearest
  localparam logic [1:0] MODE_NEAREST  = 2'd0;
  localparam logic [1:0] MODE_BILINEAR = 2'd1;
  localparam logic [1:0] MODE_BICUBIC  = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int CFG_W = 9;

  // accumulator control from the sequencer
  typedef struct packed {
    logic clear;
    logic tap;
  } imr_mac_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/imr_if.sv =====
`default_nettype none

// query and load transactions
interface imr_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [7:0]         load_col;
  logic [7:0]         load_row;
  logic [7:0]         load_red;
  logic [7:0]         load_green;
  logic [7:0]         load_blue;
  logic signed [17:0] coord_x;
  logic signed [17:0] coord_y;
  logic [1:0]         interp_mode;

  modport source (
    output valid, opcode, load_col, load_row, load_red, load_green, load_blue,
           coord_x, coord_y, interp_mode,
    input  ready
  );
  modport sink (
    input  valid, opcode, load_col, load_row, load_red, load_green, load_blue,
           coord_x, coord_y, interp_mode,
    output ready
  );
endinterface

// pixel result transactions
interface imr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/imr_ram.sv =====
`default_nettype none

module imr_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imr_coef.sv =====
`default_nettype none

// cubic convolution weights (a = -1) for one axis, pipelined through square, cube and weight registers
module imr_coef #(
  parameter int FRAC_BITS = 8,
  parameter int WW        = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [FRAC_BITS-1:0] frac,
  output logic                 valid,
  output logic signed [WW-1:0] w [4]
);

  localparam int F      = FRAC_BITS;
  localparam int WSHIFT = (3 * F > 24) ? (3 * F - 24) : 0;
  localparam int RW     = 3 * F + 3;
  localparam logic signed [RW-1:0] BIAS = RW'((64'd1 << WSHIFT) - 64'd1);

  logic [F-1:0]   u1, u2;
  logic [2*F-1:0] p, p2;
  logic [3*F-1:0] up;
  logic [2:0]     vpipe;

  logic signed [RW-1:0] s3, sp, s2u, upx;
  logic signed [RW-1:0] raw [4];
  logic signed [RW-1:0] tr  [4];

  // square then cube of the fraction
  always_ff @(posedge clk) begin
    u1 <= frac;
    p  <= frac * frac;
    u2 <= u1;
    p2 <= p;
    up <= u1 * p;
  end

  // polynomial terms at scale 2^(3F)
  always_comb begin
    s3  = $signed(RW'(1)) <<< (3 * F);
    sp  = $signed(RW'(p2)) <<< F;
    s2u = $signed(RW'(u2)) <<< (2 * F);
    upx = $signed(RW'(up));
    raw[0] = (sp <<< 1) - s2u - upx;
    raw[1] = s3 - (sp <<< 1) + upx;
    raw[2] = s2u + sp - upx;
    raw[3] = upx - sp;
    // rescale truncating toward zero
    for (int k = 0; k < 4; k++) begin
      tr[k] = (raw[k] + (raw[k][RW-1] ? BIAS : '0)) >>> WSHIFT;
    end
  end

  // weights held from the started fraction until the next start
  always_ff @(posedge clk) begin
    if (vpipe[1]) begin
      for (int k = 0; k < 4; k++) begin
        w[k] <= WW'(tr[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[1:0], start};
    end
  end

  assign valid = vpipe[2];

endmodule

`default_nettype wire

// ===== rtl/imr_mac.sv =====
`default_nettype none

// per channel multiply accumulate of pixel by tap weight
module imr_mac #(
  parameter int CWW  = 52,
  parameter int ACCW = 62
) (
  input  logic                   clk,
  input  imr_pkg::imr_mac_ctrl_t ctrl,
  input  logic [23:0]            pix,
  input  logic signed [CWW-1:0]  cw,
  output logic signed [ACCW-1:0] acc [3]
);

  import imr_pkg::*;

  logic signed [CWW+8:0] prod [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = $signed({1'b0, pix[23-8*ch -: 8]}) * cw;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (ctrl.clear) begin
        acc[ch] <= '0;
      end else if (ctrl.tap) begin
        acc[ch] <= acc[ch] + ACCW'(prod[ch]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/image_resample_interpolator_core.sv =====
`default_nettype none
`include "assert_macros.svh"

// channel  dir  handshake          payload
// req      in   valid/ready        opcode, load_*, coord_x, coord_y, interp_mode
// rsp      out  valid/ready        out_red, out_green, out_blue
// cfg      in   cfg_write strobe   cfg_index, cfg_data
//
// a load is written as accepted; a query runs S_NEAR and S_NWAIT, then S_TAPS,
// S_DRAIN, S_CHECK to interpolate, then S_DONE until the output register is free
// the single port pixel memory, read one tap per cycle, sets the query time
// reset (synchronous) clears control and sets both sizes to 256; the
// pixel memory is not cleared
// a new item is taken while a finished result waits in the output register

module image_resample_interpolator_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [0:0]               cfg_index,
  input  logic [imr_pkg::CFG_W-1:0] cfg_data,
  imr_in_if.sink                   req,
  imr_out_if.source                rsp
);

  import imr_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int IW     = 18 - F;
  localparam int SZWX   = $clog2(MAX_WIDTH + 1);
  localparam int SZWY   = $clog2(MAX_HEIGHT + 1);
  localparam int SZW    = (SZWX > SZWY) ? SZWX : SZWY;
  localparam int CMPW   = ((IW > SZW) ? IW : SZW) + 2;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int WSHIFT = (3 * F > 24) ? (3 * F - 24) : 0;
  localparam int WBITS  = 3 * F - WSHIFT;
  localparam int WW     = WBITS + 2;
  localparam int CWW    = 2 * WW;
  localparam int ACCW   = 2 * WBITS + 14;
  localparam int SH_BL  = 2 * F;
  localparam int SH_BC  = 2 * WBITS;
  localparam logic signed [ACCW-1:0] BIAS_BC = ACCW'((64'd1 << SH_BC) - 64'd1);
  localparam logic signed [WW-1:0]   ONE_W   = $signed(WW'(1)) <<< F;
  localparam logic [F-1:0]           HALF    = F'(1) << (F - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_NEAR, S_NWAIT, S_TAPS, S_DRAIN, S_CHECK, S_DONE
  } state_t;

  state_t state;

  logic [CFG_W-1:0] image_width, image_height;
  logic [SZW-1:0]   width_eff, height_eff;

  logic signed [IW-1:0] ix, iy;
  logic [F-1:0]         fx, fy;
  logic [1:0]           mode;
  logic [3:0]           tap;
  logic                 tap_d;
  logic signed [CWW-1:0] cw;
  logic [23:0]          near_px, res, out_px;
  logic                 out_valid;

  logic signed [CMPW-1:0] ipx, ipy, sx, sy, near_x, near_y, col_s, row_s;
  logic                   bl_ok, bc_ok, use_interp, bic, last_tap;
  logic [1:0]             tc, tr;
  logic signed [WW-1:0]   wsel_x, wsel_y;
  logic [AW-1:0]          near_addr, tap_addr, load_addr, mem_addr;
  logic                   mem_we, accept, load_in_range;
  logic [23:0]            rdata;

  logic                   coef_x_valid, coef_y_valid, coef_start;
  logic signed [WW-1:0]   wx [4];
  logic signed [WW-1:0]   wy [4];
  logic signed [ACCW-1:0] acc [3];
  logic signed [ACCW-1:0] q   [3];
  logic [23:0]            interp_px;
  logic                   interp_ok;
  imr_mac_ctrl_t          mac_ctrl;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(256);
      image_height <= CFG_W'(256);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective image size, zero acts as one and large values clamp
  always_comb begin
    if (image_width == '0) width_eff = SZW'(1);
    else if (int'(image_width) > MAX_WIDTH) width_eff = SZW'(MAX_WIDTH);
    else width_eff = SZW'(image_width);
    if (image_height == '0) height_eff = SZW'(1);
    else if (int'(image_height) > MAX_HEIGHT) height_eff = SZW'(MAX_HEIGHT);
    else height_eff = SZW'(image_height);
  end

  // nearest index and border tests
  always_comb begin
    ipx = CMPW'(ix);
    ipy = CMPW'(iy);
    sx  = $signed(CMPW'(width_eff));
    sy  = $signed(CMPW'(height_eff));

    if (ipx >= sx - 1) near_x = sx - 1;
    else if (ipx < 0) near_x = '0;
    else near_x = ipx + ((fx > HALF) ? CMPW'(1) : CMPW'(0));
    if (ipy >= sy - 1) near_y = sy - 1;
    else if (ipy < 0) near_y = '0;
    else near_y = ipy + ((fy > HALF) ? CMPW'(1) : CMPW'(0));

    bl_ok = (ipx >= 1) && (ipx < sx - 1) && (ipy >= 1) && (ipy < sy - 1);
    bc_ok = (ipx >= 2) && (ipx + 2 < sx) && (ipy >= 2) && (ipy + 3 < sy);

    case (mode)
      MODE_BILINEAR: use_interp = bl_ok;
      MODE_BICUBIC:  use_interp = bc_ok;
      default:       use_interp = 1'b0;
    endcase
    bic = (mode == MODE_BICUBIC);
  end

  // tap position and weights
  always_comb begin
    tc = bic ? tap[1:0] : {1'b0, tap[0]};
    tr = bic ? tap[3:2] : {1'b0, tap[1]};
    col_s = ipx - (bic ? CMPW'(1) : CMPW'(0)) + CMPW'(tc);
    row_s = ipy - (bic ? CMPW'(1) : CMPW'(0)) + CMPW'(tr);
    last_tap = bic ? (tap == 4'd15) : (tap == 4'd3);
    if (bic) begin
      wsel_x = wx[tc];
      wsel_y = wy[tr];
    end else begin
      wsel_x = tc[0] ? $signed(WW'(fx)) : ONE_W - $signed(WW'(fx));
      wsel_y = tr[0] ? $signed(WW'(fy)) : ONE_W - $signed(WW'(fy));
    end
  end

  // memory addressing, loads only while idle
  always_comb begin
    load_in_range = (int'(req.load_col) < MAX_WIDTH) && (int'(req.load_row) < MAX_HEIGHT);
    load_addr = AW'(req.load_row) * AW'(MAX_WIDTH) + AW'(req.load_col);
    near_addr = AW'(near_y) * AW'(MAX_WIDTH) + AW'(near_x);
    tap_addr  = AW'(row_s) * AW'(MAX_WIDTH) + AW'(col_s);
    mem_we    = accept && (req.opcode == OP_LOAD) && load_in_range;
    case (state)
      S_IDLE:  mem_addr = load_addr;
      S_NEAR:  mem_addr = near_addr;
      default: mem_addr = tap_addr;
    endcase
  end

  imr_ram #(.DEPTH(DEPTH), .AW(AW), .DW(24)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ({req.load_red, req.load_green, req.load_blue}),
    .rdata (rdata)
  );

  assign coef_start = accept && (req.opcode == OP_QUERY);

  imr_coef #(.FRAC_BITS(F), .WW(WW)) u_coef_x (
    .clk   (clk),
    .rst   (rst),
    .start (coef_start),
    .frac  (req.coord_x[F-1:0]),
    .valid (coef_x_valid),
    .w     (wx)
  );

  imr_coef #(.FRAC_BITS(F), .WW(WW)) u_coef_y (
    .clk   (clk),
    .rst   (rst),
    .start (coef_start),
    .frac  (req.coord_y[F-1:0]),
    .valid (coef_y_valid),
    .w     (wy)
  );

  assign mac_ctrl.clear = (state == S_NWAIT);
  assign mac_ctrl.tap   = tap_d;

  imr_mac #(.CWW(CWW), .ACCW(ACCW)) u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .pix  (rdata),
    .cw   (cw),
    .acc  (acc)
  );

  // rescale and range check of the accumulated channels
  always_comb begin
    interp_ok = 1'b1;
    for (int ch = 0; ch < 3; ch++) begin
      if (bic) begin
        q[ch] = (acc[ch] + (acc[ch][ACCW-1] ? BIAS_BC : '0)) >>> SH_BC;
      end else begin
        q[ch] = acc[ch] >>> SH_BL;
      end
      if (q[ch][ACCW-1:8] != '0) interp_ok = 1'b0;
      interp_px[23-8*ch -: 8] = q[ch][7:0];
    end
  end

  // query sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_d     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      tap_d <= (state == S_TAPS);
      // output register loads from the done state and empties on a transaction
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && req.opcode == OP_QUERY) begin
            ix    <= req.coord_x[17:F];
            iy    <= req.coord_y[17:F];
            fx    <= req.coord_x[F-1:0];
            fy    <= req.coord_y[F-1:0];
            mode  <= req.interp_mode;
            state <= S_NEAR;
          end
        end
        S_NEAR: begin
          state <= S_NWAIT;
        end
        S_NWAIT: begin
          near_px <= rdata;
          tap     <= '0;
          if (use_interp) begin
            state <= S_TAPS;
          end else begin
            res   <= rdata;
            state <= S_DONE;
          end
        end
        S_TAPS: begin
          cw    <= wsel_x * wsel_y;
          tap   <= tap + 4'd1;
          if (last_tap) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          res   <= interp_ok ? interp_px : near_px;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_px <= res;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.out_red   = out_px[23:16];
  assign rsp.out_green = out_px[15:8];
  assign rsp.out_blue  = out_px[7:0];

  `ASSERT_IMPLIES(a_load_idle, clk, rst, mem_we, state == S_IDLE)
  `ASSERT_NEXT(a_query_start, clk, rst, accept && req.opcode == OP_QUERY, state == S_NEAR)
  `ASSERT_IMPLIES(a_coef_ready, clk, rst, state == S_TAPS && $past(state) == S_NWAIT, coef_x_valid && coef_y_valid)
  `ASSERT_IMPLIES(a_bl_taps, clk, rst, state == S_TAPS && mode == MODE_BILINEAR, tap[3:2] == 2'b00)

endmodule

`default_nettype wire

// ===== sim/interpolator_checker.sv =====
`default_nettype none

module interpolator_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [0:0]                cfg_index,
  input  logic [imr_pkg::CFG_W-1:0] cfg_data,
  imr_in_if                         req,
  imr_out_if                        rsp,
  output int                        fail_count,
  output int                        pending
);
  import imr_pkg::*;

  localparam longint ONE = 256;

  logic [23:0]          pixel_mem [0:65535];
  logic [CFG_W-1:0]     width_reg;
  logic [CFG_W-1:0]     height_reg;
  logic [23:0]          expected_pixels [$];

  // register value to the size the block really uses
  function automatic longint eff_size(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > 256) return 256;
    return r;
  endfunction

  function automatic longint nearest_index(longint c, longint sz);
    longint ip;
    if (c >= (sz - 1) * ONE) return sz - 1;
    if (c < 0) return 0;
    ip = c >>> 8;
    if ((c & (ONE - 1)) > ONE / 2) ip++;
    return ip;
  endfunction

  function automatic logic [23:0] pixel_at(longint col, longint row);
    return pixel_mem[row * 256 + col];
  endfunction

  function automatic logic [23:0] nearest_pixel(longint cx, longint cy, longint w, longint h);
    return pixel_at(nearest_index(cx, w), nearest_index(cy, h));
  endfunction

  function automatic logic [23:0] bilinear_pixel(longint cx, longint cy, longint w, longint h);
    longint ix, iy, fx, fy;
    longint wx [2];
    longint wy [2];
    longint sum [3];
    logic [23:0] p;
    if (cx < ONE || cy < ONE) return nearest_pixel(cx, cy, w, h);
    ix = cx >>> 8;
    iy = cy >>> 8;
    if (ix >= w - 1 || iy >= h - 1) return nearest_pixel(cx, cy, w, h);
    fx = cx & (ONE - 1);
    fy = cy & (ONE - 1);
    wx[0] = ONE - fx; wx[1] = fx;
    wy[0] = ONE - fy; wy[1] = fy;
    sum = '{0, 0, 0};
    for (int b = 0; b < 2; b++)
      for (int a = 0; a < 2; a++) begin
        p = pixel_at(ix + a, iy + b);
        for (int ch = 0; ch < 3; ch++)
          sum[ch] += longint'(p[23 - 8 * ch -: 8]) * wx[a] * wy[b];
      end
    return {sum[0][23:16], sum[1][23:16], sum[2][23:16]};
  endfunction

  // cubic convolution kernel, a = -1, at scale 2^24
  function automatic longint cubic_weight(longint n);
    longint s;
    s = ONE;
    if (n <= s) return s * s * s - 2 * n * n * s + n * n * n;
    if (n < 2 * s) return 4 * s * s * s - 8 * n * s * s + 5 * n * n * s - n * n * n;
    return 0;
  endfunction

  function automatic logic [23:0] bicubic_pixel(longint cx, longint cy, longint w, longint h);
    longint i, j, u, v, q;
    longint wc [4];
    longint wr [4];
    longint sum [3];
    longint line [3];
    logic [23:0] p;
    logic [23:0] res;
    if (cx < 2 * ONE || cy < 2 * ONE) return nearest_pixel(cx, cy, w, h);
    i = cx >>> 8;
    j = cy >>> 8;
    if (i + 2 >= w || j + 3 >= h) return nearest_pixel(cx, cy, w, h);
    u = cx & (ONE - 1);
    v = cy & (ONE - 1);
    wc[0] = cubic_weight(ONE + u); wc[1] = cubic_weight(u);
    wc[2] = cubic_weight(ONE - u); wc[3] = cubic_weight(2 * ONE - u);
    wr[0] = cubic_weight(ONE + v); wr[1] = cubic_weight(v);
    wr[2] = cubic_weight(ONE - v); wr[3] = cubic_weight(2 * ONE - v);
    sum = '{0, 0, 0};
    for (int r = 0; r < 4; r++) begin
      line = '{0, 0, 0};
      for (int c = 0; c < 4; c++) begin
        p = pixel_at(i - 1 + c, j - 1 + r);
        for (int ch = 0; ch < 3; ch++)
          line[ch] += longint'(p[23 - 8 * ch -: 8]) * wc[c];
      end
      for (int ch = 0; ch < 3; ch++) sum[ch] += line[ch] * wr[r];
    end
    res = '0;
    // any channel out of range falls back to nearest
    for (int ch = 0; ch < 3; ch++) begin
      q = sum[ch] / (longint'(1) << 48);
      if (q < 0 || q > 255) return nearest_pixel(cx, cy, w, h);
      res[23 - 8 * ch -: 8] = q[7:0];
    end
    return res;
  endfunction

  function automatic logic [23:0] predict_pixel(longint cx, longint cy, logic [1:0] mode);
    longint w, h;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    if (mode == MODE_BILINEAR) return bilinear_pixel(cx, cy, w, h);
    if (mode == MODE_BICUBIC) return bicubic_pixel(cx, cy, w, h);
    return nearest_pixel(cx, cy, w, h);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // watch config writes, input and output transactions
  always @(posedge clk) begin
    logic [23:0] want;
    if (rst) begin
      width_reg <= 256;
      height_reg <= 256;
      expected_pixels.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg <= cfg_data;
          end
          REG_IMAGE_HEIGHT: begin
            height_reg <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.opcode == OP_LOAD)
          pixel_mem[{req.load_row, req.load_col}] = {req.load_red, req.load_green, req.load_blue};
        else
          expected_pixels.push_back(predict_pixel(longint'(req.coord_x),
                                                  longint'(req.coord_y), req.interp_mode));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel out with no query waiting");
        end else begin
          want = expected_pixels.pop_front();
          if (rsp.out_red !== want[23:16])
            report_mismatch($sformatf("out_red %0h want %0h", rsp.out_red, want[23:16]));
          if (rsp.out_green !== want[15:8])
            report_mismatch($sformatf("out_green %0h want %0h", rsp.out_green, want[15:8]));
          if (rsp.out_blue !== want[7:0])
            report_mismatch($sformatf("out_blue %0h want %0h", rsp.out_blue, want[7:0]));
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
  import imr_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int SETTLE = 40;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [0:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  int                 fail_count;
  int                 pending;

  imr_in_if  req_ch ();
  imr_out_if rsp_ch ();

  image_resample_interpolator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  interpolator_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  bit  written [0:65535];
  int  item_count;
  int  load_count;
  int  mode_count [4];
  int  img_w;
  int  img_h;
  bit  sender_calm;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #5000000;
    $display("image_resample_interpolator_core test failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    int cyc;
    cyc = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 3000) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        cyc += 400;
      end
      if (cyc > 8000 && cyc < 12000) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(99) >= 24);
    end
  end

  function automatic int near_index(int c, int sz);
    if (c >= (sz - 1) * 256) return sz - 1;
    if (c < 0) return 0;
    return (c >>> 8) + ((c & 255) > 128 ? 1 : 0);
  endfunction

  // one transaction on the request channel
  task automatic send_item(logic op, logic [7:0] col, logic [7:0] row, logic [23:0] rgb,
                           logic signed [17:0] cx, logic signed [17:0] cy, logic [1:0] mode);
    while (!sender_calm && $urandom_range(99) < 24) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.load_col <= col;
    req_ch.load_row <= row;
    req_ch.load_red <= rgb[23:16];
    req_ch.load_green <= rgb[15:8];
    req_ch.load_blue <= rgb[7:0];
    req_ch.coord_x <= cx;
    req_ch.coord_y <= cy;
    req_ch.interp_mode <= mode;
    do @(posedge clk); while (!req_ch.ready);
    item_count++;
    sender_calm = (item_count > 500 && item_count < 650);
  endtask

  task automatic load_pixel(int col, int row, logic [23:0] rgb);
    send_item(OP_LOAD, col[7:0], row[7:0], rgb, 18'($urandom), 18'($urandom), 2'($urandom));
    written[row * 256 + col] = 1'b1;
    load_count++;
  endtask

  // loads every pixel the query may read that was never written, then queries
  task automatic query_pixel(int cx, int cy, logic [1:0] mode);
    int nc, nr, ic, ir;
    nc = near_index(cx, img_w);
    nr = near_index(cy, img_h);
    if (!written[nr * 256 + nc]) load_pixel(nc, nr, 24'($urandom));
    if (cx >= 0 && cy >= 0) begin
      ic = cx >>> 8;
      ir = cy >>> 8;
      for (int r = ir - 1; r <= ir + 2; r++)
        for (int c = ic - 1; c <= ic + 2; c++)
          if (r >= 0 && c >= 0 && r < img_h && c < img_w && !written[r * 256 + c])
            load_pixel(c, r, 24'($urandom));
    end
    send_item(OP_QUERY, 8'($urandom), 8'($urandom), 24'($urandom), cx[17:0], cy[17:0], mode);
    mode_count[mode]++;
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int eff(int r);
    return r == 0 ? 1 : (r > 256 ? 256 : r);
  endfunction

  function automatic int rand_coord(int sz, int span);
    if ($urandom_range(9) == 0) return $signed($urandom_range(262143) - 131072);
    return $urandom_range(span * 256 + 1024) - 512;
  endfunction

  initial begin
    int wv [10];
    int hv [10];
    int span;
    wv = '{8, 1, 0, 256, 511, 5, 256, 16, 300, 12};
    hv = '{8, 1, 0, 256, 300, 7, 4, 256, 511, 12};
    item_count = 0;
    load_count = 0;
    mode_count = '{0, 0, 0, 0};
    sender_calm = 1'b0;
    img_w = 256;
    img_h = 256;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_LOAD;
    req_ch.load_col <= '0;
    req_ch.load_row <= '0;
    req_ch.load_red <= '0;
    req_ch.load_green <= '0;
    req_ch.load_blue <= '0;
    req_ch.coord_x <= '0;
    req_ch.coord_y <= '0;
    req_ch.interp_mode <= MODE_NEAREST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme pixels, exact half fractions, borders, every mode
    load_pixel(255, 255, 24'hffffff);
    load_pixel(0, 0, 24'h000000);
    load_pixel(10, 10, 24'hff00ff);
    query_pixel(131071, 131071, MODE_NEAREST);
    query_pixel(-131072, -131072, MODE_BILINEAR);
    query_pixel(-131072, 131071, MODE_BICUBIC);
    query_pixel(10 * 256 + 128, 10 * 256 + 128, MODE_NEAREST);
    query_pixel(10 * 256 + 129, 10 * 256 + 127, MODE_NEAREST);
    query_pixel(10 * 256 + 77, 10 * 256 + 200, MODE_BILINEAR);
    query_pixel(10 * 256 + 77, 10 * 256 + 200, MODE_BICUBIC);
    query_pixel(10 * 256, 10 * 256, MODE_BICUBIC);
    query_pixel(10 * 256 + 5, 10 * 256 + 9, 2'd3);
    query_pixel(256 + 40, 256 + 40, MODE_BILINEAR);
    query_pixel(256 + 40, 256 + 40, MODE_BICUBIC);
    query_pixel(254 * 256 + 50, 252 * 256 + 50, MODE_BICUBIC);
    query_pixel(253 * 256 + 50, 252 * 256 + 50, MODE_BICUBIC);
    query_pixel(254 * 256 + 255, 254 * 256 + 255, MODE_BILINEAR);

    // random phases over a range of image sizes
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_IMAGE_WIDTH, CFG_W'(wv[ph]));
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(hv[ph]));
      img_w = eff(wv[ph]);
      img_h = eff(hv[ph]);
      while (item_count < 20 + (ph + 1) * (ITEM_TARGET - 20) / 10) begin
        span = (img_w > 24 || img_h > 24) ? 20 : (img_w > img_h ? img_w : img_h);
        if ($urandom_range(99) < 15)
          load_pixel(int'($urandom_range(img_w - 1)), int'($urandom_range(img_h - 1)),
                     24'($urandom));
        else
          query_pixel(rand_coord(img_w, span), rand_coord(img_h, span),
                      2'($urandom_range(3)));
      end
    end
    req_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d loads and %0d/%0d/%0d/%0d nearest/bilinear/bicubic/unused queries",
             load_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("over ten image size settings, including zero and oversized registers");
    if (fail_count == 0 && pending == 0) begin
      $display("image_resample_interpolator_core test passed");
    end else begin
      $display("image_resample_interpolator_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/imr_pkg.sv
rtl/imr_if.sv
rtl/imr_ram.sv
rtl/imr_coef.sv
rtl/imr_mac.sv
rtl/image_resample_interpolator_core.sv
sim/interpolator_checker.sv
sim/testbench.sv
